FILE: design/atl_pkg.sv
// ----------------------------------------------------------------------------
// atl_pkg
// shared widths, constants and the arctangent table of the tilt angle block
// ----------------------------------------------------------------------------
package atl_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int SQ_W      = 32;
   localparam int MAG_W     = 32;
   localparam int COORD_W   = 36;
   localparam int ACC_W     = 26;
   localparam int TABLE_LEN = 24;
   localparam int ROLL_W    = 16;
   localparam int PITCH_W   = 15;
   localparam int RollLimit  = 18000;
   localparam int PitchLimit = 9000;

   localparam logic signed [ACC_W-1:0] QUARTER_TURN = 26'sd2304000;

   // atan(2^-i) in 1/256 of a hundredth of a degree
   function automatic logic signed [ACC_W-1:0] arc_angle(input int idx);
      logic signed [ACC_W-1:0] a;
      case (idx)
         0:       a = 26'sd1152000;
         1:       a = 26'sd680065;
         2:       a = 26'sd359328;
         3:       a = 26'sd182400;
         4:       a = 26'sd91554;
         5:       a = 26'sd45822;
         6:       a = 26'sd22916;
         7:       a = 26'sd11459;
         8:       a = 26'sd5730;
         9:       a = 26'sd2865;
         10:      a = 26'sd1432;
         11:      a = 26'sd716;
         12:      a = 26'sd358;
         13:      a = 26'sd179;
         14:      a = 26'sd90;
         15:      a = 26'sd45;
         16:      a = 26'sd22;
         17:      a = 26'sd11;
         18:      a = 26'sd6;
         19:      a = 26'sd3;
         20:      a = 26'sd1;
         21:      a = 26'sd1;
         default: a = 26'sd0;
      endcase
      return a;
   endfunction

endpackage

FILE: design/atl_sqrt.sv
// ----------------------------------------------------------------------------
// atl_sqrt
// pipelined restoring square root, one root bit per stage, of sq * 2^32
// ----------------------------------------------------------------------------
module atl_sqrt
   import atl_pkg::*;
#(
   parameter int SIDE_W = 48
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [SQ_W-1:0]   in_sq,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [MAG_W-1:0]  out_mag,
   output logic [SIDE_W-1:0] out_side
);

   localparam int REM_W = MAG_W + 3;

   logic              valid_ff [0:MAG_W];
   logic [REM_W-1:0]  rem_ff   [0:MAG_W];
   logic [MAG_W-1:0]  root_ff  [0:MAG_W];
   logic [SQ_W-1:0]   rad_ff   [0:MAG_W];
   logic [SIDE_W-1:0] side_ff  [0:MAG_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
      if (advance) begin
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         rad_ff[0]  <= in_sq;
         side_ff[0] <= in_side;
      end
   end

   for (genvar j = 0; j < MAG_W; j++) begin : g_bit
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      logic             take;

      // two radicand bits come down per root bit; low half of sq*2^32 is zero
      always_comb begin
         rem_sh = {rem_ff[j][REM_W-3:0], rad_ff[j][SQ_W-1:SQ_W-2]};
         trial  = REM_W'({root_ff[j], 2'b01});
         take   = (rem_sh >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[j+1] <= valid_ff[j];
         end
         if (advance) begin
            rem_ff[j+1]  <= take ? rem_sh - trial : rem_sh;
            root_ff[j+1] <= {root_ff[j][MAG_W-2:0], take};
            rad_ff[j+1]  <= {rad_ff[j][SQ_W-3:0], 2'b00};
            side_ff[j+1] <= side_ff[j];
         end
      end
   end

   assign out_valid = valid_ff[MAG_W];
   assign out_mag   = root_ff[MAG_W];
   assign out_side  = side_ff[MAG_W];

endmodule

FILE: design/atl_cordic.sv
// ----------------------------------------------------------------------------
// atl_cordic
// vectoring cordic pipeline giving a rounded, clamped atan2 in 0.01 degree
// ----------------------------------------------------------------------------
module atl_cordic
   import atl_pkg::*;
#(
   parameter int STEPS   = 16,
   parameter int LIMIT   = 18000,
   parameter int ANGLE_W = 16
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic signed [COORD_W-1:0] in_px,
   input  logic signed [COORD_W-1:0] in_py,
   output logic                      out_valid,
   output logic signed [ANGLE_W-1:0] out_angle
);

   logic                      valid_ff [0:STEPS];
   logic                      zero_ff  [0:STEPS];
   logic signed [COORD_W-1:0] xs_ff    [0:STEPS];
   logic signed [COORD_W-1:0] ys_ff    [0:STEPS];
   logic signed [ACC_W-1:0]   acc_ff   [0:STEPS];

   logic                    out_valid_ff;
   logic signed [ANGLE_W-1:0] angle_ff;

   // quarter-turn pre-rotation for the left half plane
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
      if (advance) begin
         zero_ff[0] <= (in_px == '0) && (in_py == '0);
         if (in_px < 0) begin
            if (in_py >= 0) begin
               xs_ff[0]  <= in_py;
               ys_ff[0]  <= -in_px;
               acc_ff[0] <= QUARTER_TURN;
            end else begin
               xs_ff[0]  <= -in_py;
               ys_ff[0]  <= in_px;
               acc_ff[0] <= -QUARTER_TURN;
            end
         end else begin
            xs_ff[0]  <= in_px;
            ys_ff[0]  <= in_py;
            acc_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [ACC_W-1:0] ARC = arc_angle(i);
      logic signed [COORD_W-1:0] dx;
      logic signed [COORD_W-1:0] dy;

      assign dx = ys_ff[i] >>> i;
      assign dy = xs_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (advance) begin
            zero_ff[i+1] <= zero_ff[i];
            if (ys_ff[i] >= 0) begin
               xs_ff[i+1]  <= xs_ff[i] + dx;
               ys_ff[i+1]  <= ys_ff[i] - dy;
               acc_ff[i+1] <= acc_ff[i] + ARC;
            end else begin
               xs_ff[i+1]  <= xs_ff[i] - dx;
               ys_ff[i+1]  <= ys_ff[i] + dy;
               acc_ff[i+1] <= acc_ff[i] - ARC;
            end
         end
      end
   end

   localparam logic signed [ACC_W-1:0] LIM_POS = ACC_W'(LIMIT);
   localparam logic signed [ACC_W-1:0] LIM_NEG = -ACC_W'(LIMIT);

   logic signed [ACC_W-1:0] acc_mag;
   logic signed [ACC_W-1:0] rnd_mag;
   logic signed [ACC_W-1:0] rnd_val;
   logic signed [ACC_W-1:0] clamped;

   // round half away from zero, then clamp; the zero vector gives zero
   always_comb begin
      acc_mag = (acc_ff[STEPS] < 0) ? -acc_ff[STEPS] : acc_ff[STEPS];
      rnd_mag = (acc_mag + ACC_W'(128)) >>> 8;
      rnd_val = (acc_ff[STEPS] < 0) ? -rnd_mag : rnd_mag;
      if (zero_ff[STEPS]) begin
         clamped = '0;
      end else if (rnd_val > LIM_POS) begin
         clamped = LIM_POS;
      end else if (rnd_val < LIM_NEG) begin
         clamped = LIM_NEG;
      end else begin
         clamped = rnd_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= valid_ff[STEPS];
      end
      if (advance) begin
         angle_ff <= clamped[ANGLE_W-1:0];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_angle = angle_ff;

endmodule

FILE: design/accel_tilt_angles_top.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles_top
// roll and pitch angles from one accelerometer sample triple
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one word per sample: accel_x, accel_y, accel_z
//   rsp channel returns one word per sample: roll_angle = atan2(y, z) and
//   pitch_angle = atan2(-x, |(y,z)|), both in signed hundredths of a degree
//   throughput: one word per clock while rsp is not stalled
//   stages from accept to rsp_valid: input register, square and sum
//     stages, 33 square root registers, pre-rotation, STEPS cordic
//     stages, round and clamp, with STEPS = min(ROTATION_STEPS, 24)
//   the whole pipeline moves as one; a stall on a valid rsp word freezes every stage
//   and raises req_stall in the same cycle, so nothing is dropped or doubled
//   reset (synchronous) clears all valid bits; payload needs no reset
// ----------------------------------------------------------------------------
module accel_tilt_angles_top
   import atl_pkg::*;
#(
   parameter int ROTATION_STEPS = 16
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [SAMPLE_W-1:0] req_accel_x,
   input  logic signed [SAMPLE_W-1:0] req_accel_y,
   input  logic signed [SAMPLE_W-1:0] req_accel_z,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [ROLL_W-1:0]  rsp_roll_angle,
   output logic signed [PITCH_W-1:0] rsp_pitch_angle
);

   // step count beyond the table length is held at the table length
   localparam int STEPS  = (ROTATION_STEPS > TABLE_LEN) ? TABLE_LEN : ROTATION_STEPS;
   localparam int SIDE_W = 3 * SAMPLE_W;

   logic advance;

   // stage 1: input register
   logic                       s1_valid_ff;
   logic signed [SAMPLE_W-1:0] s1_x_ff, s1_y_ff, s1_z_ff;
   // stage 2: squares
   logic                       s2_valid_ff;
   logic signed [SAMPLE_W-1:0] s2_x_ff, s2_y_ff, s2_z_ff;
   logic signed [SQ_W-1:0]     s2_yy_ff, s2_zz_ff;
   // stage 3: sum of squares
   logic                       s3_valid_ff;
   logic [SIDE_W-1:0]          s3_side_ff;
   logic [SQ_W-1:0]            s3_sq_ff;

   logic                       sq_valid;
   logic [MAG_W-1:0]           sq_mag;
   logic [SIDE_W-1:0]          sq_side;
   logic signed [SAMPLE_W-1:0] sq_x, sq_y, sq_z;

   logic signed [COORD_W-1:0]  roll_px, roll_py, pitch_px, pitch_py;
   logic                       roll_valid, pitch_valid;

   // whole pipeline holds while a finished word waits on a stalled receiver
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s1_x_ff    <= req_accel_x;
         s1_y_ff    <= req_accel_y;
         s1_z_ff    <= req_accel_z;
         s2_x_ff    <= s1_x_ff;
         s2_y_ff    <= s1_y_ff;
         s2_z_ff    <= s1_z_ff;
         s2_yy_ff   <= s1_y_ff * s1_y_ff;
         s2_zz_ff   <= s1_z_ff * s1_z_ff;
         // each square is at most 2^30, so the sum fits unsigned 32 bits
         s3_sq_ff   <= SQ_W'(unsigned'(s2_yy_ff)) + SQ_W'(unsigned'(s2_zz_ff));
         s3_side_ff <= {s2_x_ff, s2_y_ff, s2_z_ff};
      end
   end

   // magnitude of (y, z) scaled by 2^16
   atl_sqrt #(
      .SIDE_W (SIDE_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s3_valid_ff),
      .in_sq     (s3_sq_ff),
      .in_side   (s3_side_ff),
      .out_valid (sq_valid),
      .out_mag   (sq_mag),
      .out_side  (sq_side)
   );

   assign {sq_x, sq_y, sq_z} = sq_side;

   // coordinates scaled by 2^16; -x at full width so -32768 turns positive
   assign roll_px  = COORD_W'(sq_z) <<< 16;
   assign roll_py  = COORD_W'(sq_y) <<< 16;
   assign pitch_px = COORD_W'(sq_mag);
   assign pitch_py = (-COORD_W'(sq_x)) <<< 16;

   atl_cordic #(
      .STEPS   (STEPS),
      .LIMIT   (RollLimit),
      .ANGLE_W (ROLL_W)
   ) u_roll (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sq_valid),
      .in_px     (roll_px),
      .in_py     (roll_py),
      .out_valid (roll_valid),
      .out_angle (rsp_roll_angle)
   );

   atl_cordic #(
      .STEPS   (STEPS),
      .LIMIT   (PitchLimit),
      .ANGLE_W (PITCH_W)
   ) u_pitch (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sq_valid),
      .in_px     (pitch_px),
      .in_py     (pitch_py),
      .out_valid (pitch_valid),
      .out_angle (rsp_pitch_angle)
   );

   // both cordic pipes run in lockstep
   assign rsp_valid = roll_valid && pitch_valid;

endmodule

FILE: verif/accel_tilt_angles_top_tb.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles_top_tb
// self-checking bench for the roll and pitch angle block: sample words go in
// through bursts with random gaps, every angle word is compared with a
// behavioral cordic model while the receiver stalls on its own pattern
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accel_tilt_angles_top_tb
   import atl_pkg::*;
;

   localparam int STEPS = 16;
   localparam int ROTATIONS = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;
   localparam int LATENCY = 3 + 32 + ROTATIONS + 2;

   typedef struct packed {
      logic signed [ROLL_W-1:0]  roll;
      logic signed [PITCH_W-1:0] pitch;
   } angles_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SAMPLE_W-1:0] req_accel_x = '0;
   logic signed [SAMPLE_W-1:0] req_accel_y = '0;
   logic signed [SAMPLE_W-1:0] req_accel_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [ROLL_W-1:0]  rsp_roll_angle;
   logic signed [PITCH_W-1:0] rsp_pitch_angle;

   angles_type pending_angles[$];
   int         error_count = 0;
   int         burst_left = 0;

   accel_tilt_angles_top #(.ROTATION_STEPS(STEPS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_accel_x(req_accel_x), .req_accel_y(req_accel_y),
      .req_accel_z(req_accel_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_roll_angle(rsp_roll_angle), .rsp_pitch_angle(rsp_pitch_angle)
   );

   always #1 clock = ~clock;

   // floor square root of a 64-bit value, bit by bit
   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > n) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (n >= res + bit_w) begin
            n = n - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // atan2(py, px) in hundredths of a degree, held to +-limit
   function automatic longint vector_angle(input longint px, input longint py,
                                           input longint limit);
      longint acc, xs, ys, t, dx, dy, mag, r;
      acc = 0;
      xs = px;
      ys = py;
      if (px == 0 && py == 0) return 0;
      if (xs < 0) begin
         t = xs;
         if (ys >= 0) begin
            xs = ys;  ys = -t;  acc = QUARTER_TURN;
         end else begin
            xs = -ys; ys = t;   acc = -QUARTER_TURN;
         end
      end
      for (int i = 0; i < ROTATIONS; i++) begin
         dx = ys >>> i;
         dy = xs >>> i;
         if (ys >= 0) begin
            xs += dx; ys -= dy; acc += arc_angle(i);
         end else begin
            xs -= dx; ys += dy; acc -= arc_angle(i);
         end
      end
      mag = (acc < 0) ? -acc : acc;
      r = (mag + 128) / 256;   // ties away from zero
      if (acc < 0) r = -r;
      if (r > limit) r = limit;
      if (r < -limit) r = -limit;
      return r;
   endfunction

   function automatic angles_type tilt_angles(input logic signed [SAMPLE_W-1:0] ax,
                                              input logic signed [SAMPLE_W-1:0] ay,
                                              input logic signed [SAMPLE_W-1:0] az);
      angles_type a;
      longint x, y, z, mag;
      x = longint'(ax); y = longint'(ay); z = longint'(az);
      mag = root_floor(longint'(y * y + z * z) << 32);
      a.roll  = ROLL_W'(vector_angle(z * 65536, y * 65536, RollLimit));
      a.pitch = PITCH_W'(vector_angle(mag, -x * 65536, PitchLimit));
      return a;
   endfunction

   // sender: bursts of random length with random gaps in between
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] ax,
                              input logic signed [SAMPLE_W-1:0] ay,
                              input logic signed [SAMPLE_W-1:0] az);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      pending_angles.push_back(tilt_angles(ax, ay, az));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // receiver stall pattern: quiet stretches, light and heavy ones
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         case (($time / 400) % 3)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      angles_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_angles.size() == 0) begin
            $error("unexpected angle word roll=%0d pitch=%0d",
                   rsp_roll_angle, rsp_pitch_angle);
            error_count++;
         end else begin
            want = pending_angles.pop_front();
            if (rsp_roll_angle !== want.roll) begin
               $error("roll_angle expected %0d got %0d", want.roll, rsp_roll_angle);
               error_count++;
            end
            if (rsp_pitch_angle !== want.pitch) begin
               $error("pitch_angle expected %0d got %0d", want.pitch,
                      rsp_pitch_angle);
               error_count++;
            end
         end
      end
   end

   // extremes, axes, zero vector, negative z axis, overshoot near limits
   task automatic test_directed();
      send_sample(0, 0, 0);
      send_sample(16'sh7fff, 0, 0);
      send_sample(-16'sh8000, 0, 0);
      send_sample(0, 0, -16'sd100);
      send_sample(0, 0, -16'sh8000);
      send_sample(0, 16'sd1, -16'sh8000);
      send_sample(0, -16'sd1, -16'sh8000);
      send_sample(0, 16'sh7fff, 0);
      send_sample(0, -16'sh8000, 0);
      send_sample(0, 0, 16'sh7fff);
      send_sample(-16'sh8000, -16'sh8000, -16'sh8000);
      send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_sample(-16'sh8000, 16'sh7fff, -16'sh8000);
      send_sample(16'sd1, 0, 0);
      send_sample(-16'sd1, 0, 16'sd1);
      send_sample(0, -16'sd1, -16'sd1);
      send_sample(16'sd16384, 0, 16'sd16384);
      send_sample(-16'sd1, -16'sd1, 16'sd1);
      send_sample(16'sh5555, -16'sh5556, 16'sh2aaa);
   endtask

   // random samples: mostly full range, some tiny and some near an axis
   task automatic test_random();
      logic signed [SAMPLE_W-1:0] v[3];
      for (int n = 0; n < 900; n++) begin
         for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 5))
               0: v[k] = SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
               1: v[k] = '0;
               default: v[k] = SAMPLE_W'($urandom);
            endcase
         end
         send_sample(v[0], v[1], v[2]);
      end
   endtask

   initial begin
      int waited;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      req_valid <= 1'b0;
      waited = 0;
      while (pending_angles.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && pending_angles.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // timeout
   initial begin
      #400000;
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: accel_tilt_angles_top.f
design/atl_pkg.sv
design/atl_sqrt.sv
design/atl_cordic.sv
design/accel_tilt_angles_top.sv
verif/accel_tilt_angles_top_tb.sv
